// ===== src/chm_pkg.sv =====
`default_nettype none

package chm_pkg;

  // default table size and the most words one command may return
  localparam int DEF_TABLE_DEPTH = 32;
  localparam int MAX_RESULTS     = 32;

  // command codes
  localparam logic [2:0] MODE_ADD   = 3'd0;
  localparam logic [2:0] MODE_DEL   = 3'd1;
  localparam logic [2:0] MODE_CLEAR = 3'd2;
  localparam logic [2:0] MODE_INDEX = 3'd3;
  localparam logic [2:0] MODE_TYPE  = 3'd4;

  // status codes
  localparam logic [1:0] STAT_DONE    = 2'd0;
  localparam logic [1:0] STAT_IGNORED = 2'd1;
  localparam logic [1:0] STAT_NOMATCH = 2'd2;
  localparam logic [1:0] STAT_ENTRY   = 2'd3;

  localparam logic [7:0] FREE_UNIT = 8'd255;

  // one table entry as stored
  typedef struct packed {
    logic [2:0] ctype;
    logic [7:0] uidx;
    logic [7:0] ulvl;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  localparam entry_t FREE_ENTRY = '{ctype: 3'd0, uidx: FREE_UNIT, ulvl: FREE_UNIT};

endpackage

`default_nettype wire

// ===== src/channel_map_table.sv =====
`default_nettype none

// Channel map table: maps each management channel to a type, a transport
// unit index and a unit level.
// Command channel: a command word (mode, channel_index, unit_index,
// unit_level, channel_type) is taken at a clock edge with start high and
// busy low. busy stays high until the command's last result is out.
// Result channel: each result word is on the result ports for one cycle
// with valid high; last marks the final word of a command. The receiver
// cannot stall, so every word must be taken as it comes.
// Add, delete, delete all, get by index and ignored commands give one
// result. A get by type walks the active entries through the table's
// single read port, one entry per cycle. Each match is held back until
// the next match or the end of the walk, so the final word can carry last.
// active_channels is written through cfg_write/cfg_data; the user must
// write it only while idle, and the block leaves this to the user.
// Reset: synchronous, active high; every entry reads as free (per-entry
// valid flags are cleared, so no clearing pass is needed) and
// active_channels returns to 32.
module channel_map_table import chm_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write,
  input  wire logic [5:0] cfg_data,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [2:0] mode,
  input  wire logic [5:0] channel_index,
  input  wire logic [7:0] unit_index,
  input  wire logic [7:0] unit_level,
  input  wire logic [2:0] channel_type,
  output logic            valid,
  output logic [1:0]      status,
  output logic [4:0]      entry_index,
  output logic [2:0]      entry_type,
  output logic [7:0]      entry_unit_index,
  output logic [7:0]      entry_unit_level,
  output logic            last
);

  localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CAP = (TABLE_DEPTH < MAX_RESULTS) ? TABLE_DEPTH : MAX_RESULTS;
  localparam logic [5:0] CAP_V = 6'(CAP);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOOK = 3'b010,
    ST_SCAN = 3'b100
  } state_t;

  state_t state;

  logic [5:0] active_channels;
  logic [5:0] count;

  // latched command word
  logic [2:0] cmd_mode;
  logic [5:0] cmd_ch;
  logic [7:0] cmd_uidx;
  logic [7:0] cmd_ulvl;
  logic [2:0] cmd_type;

  // table storage and per-entry in-use flags
  logic [TABLE_DEPTH-1:0] in_use;
  logic [AW-1:0]          rd_addr;
  logic [ENTRY_W-1:0]     rd_data;
  entry_t                 rd_entry;
  entry_t                 rd_eff;
  logic                   rd_valid;
  logic                   ram_we;
  entry_t                 ram_wdata;

  // type search walk
  logic [5:0] scan;
  logic       chk_vld;
  logic [5:0] chk_idx;
  logic       hold_vld;
  logic [4:0] hold_idx;
  entry_t     hold_entry;

  logic in_range;
  logic del_hit;
  logic type_hit;

  assign busy = (state != ST_IDLE);

  // effective count: smaller of the register, the table depth and 32
  assign count = (active_channels > CAP_V) ? CAP_V : active_channels;

  assign in_range  = (cmd_ch < count);
  assign rd_entry  = entry_t'(rd_data);
  assign rd_eff    = rd_valid ? rd_entry : FREE_ENTRY;
  assign del_hit   = rd_valid && (rd_entry.uidx == cmd_uidx) && (rd_entry.ulvl == cmd_ulvl);
  assign type_hit  = chk_vld && (rd_eff.ctype == cmd_type);

  // read address: command index at accept, walk pointer while searching
  assign rd_addr = (state == ST_SCAN) ? scan[AW-1:0] : channel_index[AW-1:0];

  // add with a real unit index writes the entry; other changes touch flags
  assign ram_we    = (state == ST_LOOK) && (cmd_mode == MODE_ADD) && in_range &&
                     (cmd_uidx != FREE_UNIT);
  assign ram_wdata = '{ctype: cmd_type, uidx: cmd_uidx, ulvl: cmd_ulvl};

  chm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cmd_ch[AW-1:0]),
    .wdata (ram_wdata),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // in-use flag read alongside the table
  always_ff @(posedge clk) begin
    rd_valid <= in_use[rd_addr];
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      active_channels <= 6'd32;
    end else if (cfg_write) begin
      active_channels <= cfg_data;
    end
  end

  // command capture
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd_mode <= mode;
      cmd_ch   <= channel_index;
      cmd_uidx <= unit_index;
      cmd_ulvl <= unit_level;
      cmd_type <= channel_type;
    end
  end

  // sequencer, flags and result word
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      in_use   <= '0;
      valid    <= 1'b0;
      chk_vld  <= 1'b0;
      hold_vld <= 1'b0;
      scan     <= '0;
    end else begin
      valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_LOOK;
          end
        end

        ST_LOOK: begin
          state            <= ST_IDLE;
          valid            <= 1'b1;
          last             <= 1'b1;
          status           <= STAT_IGNORED;
          entry_index      <= '0;
          entry_type       <= '0;
          entry_unit_index <= '0;
          entry_unit_level <= '0;
          case (cmd_mode)
            MODE_CLEAR: begin
              in_use <= '0;
              status <= STAT_DONE;
            end
            MODE_TYPE: begin
              valid    <= 1'b0;
              state    <= ST_SCAN;
              scan     <= '0;
              chk_vld  <= 1'b0;
              hold_vld <= 1'b0;
            end
            MODE_ADD: begin
              if (in_range) begin
                in_use[cmd_ch[AW-1:0]] <= (cmd_uidx != FREE_UNIT);
                status                 <= STAT_DONE;
              end
            end
            MODE_DEL: begin
              if (in_range) begin
                if (del_hit) begin
                  in_use[cmd_ch[AW-1:0]] <= 1'b0;
                  status                 <= STAT_DONE;
                end else begin
                  status <= STAT_NOMATCH;
                end
              end
            end
            MODE_INDEX: begin
              if (in_range) begin
                if (rd_valid) begin
                  status           <= STAT_ENTRY;
                  entry_index      <= cmd_ch[4:0];
                  entry_type       <= rd_entry.ctype;
                  entry_unit_index <= rd_entry.uidx;
                  entry_unit_level <= rd_entry.ulvl;
                end else begin
                  status <= STAT_NOMATCH;
                end
              end
            end
            default: begin
              status <= STAT_IGNORED;
            end
          endcase
        end

        ST_SCAN: begin
          // issue one read per cycle until the count is reached
          if (scan < count) begin
            scan    <= scan + 6'd1;
            chk_vld <= 1'b1;
            chk_idx <= scan;
          end else begin
            chk_vld <= 1'b0;
          end
          // hold each hit back until the next hit or the end of the walk so the final one can carry last
          if (type_hit) begin
            if (hold_vld) begin
              valid            <= 1'b1;
              last             <= 1'b0;
              status           <= STAT_ENTRY;
              entry_index      <= hold_idx;
              entry_type       <= hold_entry.ctype;
              entry_unit_index <= hold_entry.uidx;
              entry_unit_level <= hold_entry.ulvl;
            end
            hold_vld   <= 1'b1;
            hold_idx   <= chk_idx[4:0];
            hold_entry <= rd_eff;
          end else if (!chk_vld && !(scan < count)) begin
            state <= ST_IDLE;
            valid <= 1'b1;
            last  <= 1'b1;
            if (hold_vld) begin
              status           <= STAT_ENTRY;
              entry_index      <= hold_idx;
              entry_type       <= hold_entry.ctype;
              entry_unit_index <= hold_entry.uidx;
              entry_unit_level <= hold_entry.ulvl;
            end else begin
              status           <= STAT_NOMATCH;
              entry_index      <= '0;
              entry_type       <= '0;
              entry_unit_index <= '0;
              entry_unit_level <= '0;
            end
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // a command ends only with its last word
  a_end_with_last: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $fell(busy) |-> valid && last)
    else $error("busy dropped without a last word");

  // the last word leaves the block idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    valid && last |-> !busy)
    else $error("last word while still busy");

  // only returned entries of a type search come without last
  a_mid_word: assert property (@(posedge clk) disable iff (rst)
    valid && !last |-> busy && (status == STAT_ENTRY))
    else $error("word without last outside a type search");

  // words only come out of a running command
  a_word_source: assert property (@(posedge clk) disable iff (rst)
    valid |-> $past(busy))
    else $error("result word with no command running");

endmodule

`default_nettype wire

// ===== src/chm_ram.sv =====
`default_nettype none

module chm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
